/* design/dtq_pkg.sv */
`default_nettype none

package dtq_pkg;

    // request kinds carried on s_tuser
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_ADD  = 2'd1;
    localparam logic [1:0] ACT_DEL  = 2'd2;

    localparam int ACT_W   = 2;
    localparam int ID_W    = 4;
    localparam int DELAY_W = 31;
    localparam int TIME_W  = 32;

    localparam logic [TIME_W-1:0] SIGN32 = 32'h8000_0000;

    // control from the sequencer to the minimum tracker
    typedef struct packed {
        logic clear;
        logic sample;
    } pick_ctl_t;

endpackage

`default_nettype wire

/* design/dtq_best.sv */
`default_nettype none

module dtq_best import dtq_pkg::*; #(
    parameter int IDX_W = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pick_ctl_t          ctl,
    input  wire logic [TIME_W-1:0]  now_ms,
    input  wire logic [TIME_W-1:0]  cand_dl,
    input  wire logic               cand_armed,
    input  wire logic [IDX_W-1:0]   cand_idx,
    output logic                    best_vld,
    output logic [IDX_W-1:0]        best_idx,
    output logic [IDX_W:0]          due_cnt
);

    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] key;
    logic              due;
    logic              best_vld_reg;
    logic              best_vld_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;
    logic [TIME_W-1:0] best_key_reg;
    logic [TIME_W-1:0] best_key_next;
    logic [IDX_W:0]    due_cnt_reg;
    logic [IDX_W:0]    due_cnt_next;

    // wrapping signed difference; key order equals signed order
    assign diff = cand_dl - now_ms;
    assign key  = diff ^ SIGN32;
    assign due  = cand_armed && ((diff == '0) || diff[TIME_W-1]);

    always_comb begin
        best_vld_next = best_vld_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        due_cnt_next  = due_cnt_reg;
        if (ctl.clear) begin
            best_vld_next = 1'b0;
            due_cnt_next  = '0;
        end else if (ctl.sample && due) begin
            due_cnt_next = due_cnt_reg + 1'b1;
            // strict compare: ascending scan keeps the lower index on ties
            if (!best_vld_reg || (key < best_key_reg)) begin
                best_vld_next = 1'b1;
                best_idx_next = cand_idx;
                best_key_next = key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_vld_reg <= 1'b0;
            due_cnt_reg  <= '0;
        end else begin
            best_vld_reg <= best_vld_next;
            due_cnt_reg  <= due_cnt_next;
        end
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
    end

    assign best_vld = best_vld_reg;
    assign best_idx = best_idx_reg;
    assign due_cnt  = due_cnt_reg;

endmodule

`default_nettype wire

/* design/deadline_timer_queue_unit.sv */
// Add, delete or unused request: its single result is loaded from ST_EMIT into the output register
// once that is free, and the next request can be taken after that load. One request is worked on at a time.
// Tick: each scan pass reads every deadline entry through the one memory read port,
// then loads one result into the output; a tick gives one result per fired timer, one pass each
// (one pass with an empty result when nothing fires), and a full output stalls the next pass.
// Reset (aresetn low, synchronous): clock 0, all timers disarmed, output empty; no clearing pass.
`default_nettype none

module deadline_timer_queue_unit import dtq_pkg::*; #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // timer_id[3:0], delay_ms[34:4], zero pad
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // fired_id[3:0], zero pad
    output logic [0:0]       m_tuser,   // fired[0]
    output logic             m_tlast    // last result of the request
);

    localparam int IDX_W = $clog2(NUM_TIMERS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] NUM_C = CNT_W'(NUM_TIMERS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // request fields
    logic [ACT_W-1:0]   in_action;
    logic [ID_W-1:0]    in_id;
    logic [DELAY_W-1:0] in_delay;
    logic               id_ok;
    logic [IDX_W-1:0]   in_idx;

    assign in_action = s_tuser[ACT_W-1:0];
    assign in_id     = s_tdata[ID_W-1:0];
    assign in_delay  = s_tdata[ID_W+DELAY_W-1:ID_W];
    assign id_ok     = (32'(in_id) < 32'(NUM_TIMERS));
    assign in_idx    = IDX_W'(in_id);

    logic [1:0]            state_reg, state_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [CNT_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  res_fired_reg, res_fired_next;
    logic [ID_W-1:0]       res_id_reg, res_id_next;
    logic                  res_last_reg, res_last_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  m_fired_reg, m_fired_next;
    logic [ID_W-1:0]       m_id_reg, m_id_next;
    logic                  m_last_reg, m_last_next;

    logic                  wr_en;
    logic                  rd_en;
    logic [TIME_W-1:0]     rd_data;
    logic                  slot_free;
    logic                  pass_done;
    pick_ctl_t             pick_ctl;
    logic                  best_vld;
    logic [IDX_W-1:0]      best_idx;
    logic [CNT_W-1:0]      due_cnt;

    // deadline store: one write port (add), one registered read port (scan)
    logic [TIME_W-1:0] dl_mem [NUM_TIMERS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dl_mem[in_idx] <= now_reg + {1'b0, in_delay};
        end
        if (rd_en) begin
            rd_data <= dl_mem[scan_addr_reg[IDX_W-1:0]];
        end
    end

    // running minimum over one pass
    dtq_best #(
        .IDX_W (IDX_W)
    ) u_best (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (pick_ctl),
        .now_ms     (now_reg),
        .cand_dl    (rd_data),
        .cand_armed (armed_reg[rd_idx_reg]),
        .cand_idx   (rd_idx_reg),
        .best_vld   (best_vld),
        .best_idx   (best_idx),
        .due_cnt    (due_cnt)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign slot_free = !m_tvalid_reg || m_tready;
    // all addresses issued and the last read consumed
    assign pass_done = (scan_addr_reg == NUM_C) && !rd_vld_reg;

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        armed_next      = armed_reg;
        scan_addr_next  = scan_addr_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        res_fired_next  = res_fired_reg;
        res_id_next     = res_id_reg;
        res_last_next   = res_last_reg;
        pick_ctl.clear  = 1'b0;
        pick_ctl.sample = rd_vld_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_fired_next    = m_fired_reg;
        m_id_next       = m_id_reg;
        m_last_next     = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // non-tick requests give one empty result
                    res_fired_next = 1'b0;
                    res_id_next    = '0;
                    res_last_next  = 1'b1;
                    state_next     = ST_EMIT;
                    case (in_action)
                        ACT_TICK: begin
                            now_next       = now_reg + 1'b1;
                            scan_addr_next = '0;
                            pick_ctl.clear = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        ACT_ADD: begin
                            if (id_ok) begin
                                wr_en              = 1'b1;
                                armed_next[in_idx] = 1'b1;
                            end
                        end
                        ACT_DEL: begin
                            if (id_ok) begin
                                armed_next[in_idx] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_addr_reg != NUM_C) begin
                    rd_en          = 1'b1;
                    scan_addr_next = scan_addr_reg + 1'b1;
                end else if (pass_done) begin
                    // earliest due timer is fired and disarmed; the due count
                    // tells whether it is the final one of this tick
                    res_fired_next = best_vld;
                    res_id_next    = best_vld ? ID_W'(best_idx) : '0;
                    res_last_next  = (due_cnt <= CNT_W'(1));
                    if (best_vld) begin
                        armed_next[best_idx] = 1'b0;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_fired_next  = res_fired_reg;
                    m_id_next     = res_id_reg;
                    m_last_next   = res_last_reg;
                    if (res_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        scan_addr_next = '0;
                        pick_ctl.clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_vld_next = rd_en;
    assign rd_idx_next = scan_addr_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            armed_reg     <= '0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            armed_reg     <= armed_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= rd_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        rd_idx_reg    <= rd_idx_next;
        res_fired_reg <= res_fired_next;
        res_id_reg    <= res_id_next;
        res_last_reg  <= res_last_next;
        m_fired_reg   <= m_fired_next;
        m_id_reg      <= m_id_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {{(8 - ID_W){1'b0}}, m_id_reg};
    assign m_tuser[0] = m_fired_reg;
    assign m_tlast    = m_last_reg;

    // a timer reported at the end of a pass is disarmed afterwards
    a_fire_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && pass_done && best_vld)
        |=> !armed_reg[$past(best_idx)])
        else $error("fired timer still armed");

    // a found minimum is always counted among the due timers
    a_best_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        best_vld |-> (due_cnt != '0))
        else $error("best timer without due count");

    // an empty result is always the final one and carries index zero
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_fired_reg) |-> (m_last_reg && (m_id_reg == '0)))
        else $error("empty result not final");

    // an accepted request always leaves the idle state
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("request accepted without work");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
    import dtq_pkg::*;

    localparam int NUM_TIMERS = 16;
    localparam int STALL_LIMIT = 4000;  // cycles without any handshake before giving up
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;  // unused kind, block ignores it

    typedef struct packed {
        logic              fired;
        logic [ID_W-1:0]   id;
        logic              last;
    } expiry_t;

    // Tracks the timer table alongside the block and holds the expiries still owed.
    class timer_scoreboard;
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] due_at [NUM_TIMERS];
        bit                armed [NUM_TIMERS];
        expiry_t           owed_q [$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       expiries;
        int unsigned       widest_volley;

        function new();
            clock_ms = '0;
            foreach (armed[i]) begin
                armed[i] = 1'b0;
                due_at[i] = '0;
            end
            errors = 0;
            checked = 0;
            expiries = 0;
            widest_volley = 0;
        endfunction

        function int unsigned outstanding();
            return owed_q.size();
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                   logic [DELAY_W-1:0] delay_ms);
            int          best;
            int          count;
            logic [TIME_W-1:0] gap_ms;
            logic [TIME_W-1:0] key;
            logic [TIME_W-1:0] best_key;
            expiry_t     r;
            count = 0;
            case (act)
                ACT_TICK: begin
                    clock_ms = clock_ms + 1;
                    // earliest deadline first, lower index wins a tie
                    do begin
                        best = -1;
                        best_key = '0;
                        for (int i = 0; i < NUM_TIMERS; i++) begin
                            gap_ms = due_at[i] - clock_ms;
                            key = gap_ms ^ SIGN32;
                            if (armed[i] && (gap_ms == '0 || gap_ms[TIME_W-1]) &&
                                (best < 0 || key < best_key)) begin
                                best = i;
                                best_key = key;
                            end
                        end
                        if (best >= 0) begin
                            armed[best] = 1'b0;
                            r = '{fired: 1'b1, id: best[ID_W-1:0], last: 1'b0};
                            owed_q.push_back(r);
                            count++;
                        end
                    end while (best >= 0);
                end
                ACT_ADD: begin
                    if (id < NUM_TIMERS) begin
                        due_at[id] = clock_ms + TIME_W'(delay_ms);
                        armed[id] = 1'b1;
                    end
                end
                ACT_DEL: begin
                    if (id < NUM_TIMERS)
                        armed[id] = 1'b0;
                end
                default: ;
            endcase
            if (count == 0) begin
                r = '{fired: 1'b0, id: '0, last: 1'b1};
                owed_q.push_back(r);
            end else begin
                r = owed_q.pop_back();
                r.last = 1'b1;
                owed_q.push_back(r);
                if (count > widest_volley)
                    widest_volley = count;
            end
        endfunction

        function void check_result(logic fired, logic [7:0] data, logic last);
            expiry_t e;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing owed: fired=%0d data=%0h last=%0d",
                         $time, fired, data, last);
                return;
            end
            e = owed_q.pop_front();
            checked++;
            if (e.fired)
                expiries++;
            if (fired !== e.fired) begin
                errors++;
                $display("%0t: fired mismatch: expected %0d, got %0d", $time, e.fired, fired);
            end
            if (data !== {4'b0, e.id}) begin
                errors++;
                $display("%0t: fired_id mismatch: expected %0h, got %0h",
                         $time, {4'b0, e.id}, data);
            end
            if (last !== e.last) begin
                errors++;
                $display("%0t: last mismatch: expected %0d, got %0d", $time, e.last, last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // timer_id[3:0], delay_ms[34:4], zero pad
    logic [1:0]  s_tuser = '0;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // fired_id[3:0], zero pad
    logic [0:0]  m_tuser;        // fired[0]
    logic        m_tlast;

    timer_scoreboard sb;
    bit          quiet = 1'b0;   // no gaps on either side while set
    int unsigned item_count = 0;
    int unsigned n_tick = 0, n_add = 0, n_del = 0, n_none = 0;
    int unsigned ready_hold = 0;
    int unsigned stall_cycles = 0;

    deadline_timer_queue_unit #(.NUM_TIMERS(NUM_TIMERS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, the odd long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_hold = 0;
        end else if (ready_hold != 0) begin
            m_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
                ready_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser[0], m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results still owed",
                     $time, stall_cycles, sb.outstanding());
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_req(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                            input logic [DELAY_W-1:0] delay_ms);
        int unsigned gap;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {5'b0, delay_ms, id};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(act, id, delay_ms);
        case (act)
            ACT_TICK: n_tick++;
            ACT_ADD:  n_add++;
            ACT_DEL:  n_del++;
            default:  n_none++;
        endcase
        if (act != ACT_NONE)
            item_count++;
    endtask

    // hold the sender until every owed result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    task automatic random_sequence();
        int unsigned kind;
        int unsigned pick;
        int unsigned j;
        logic [ID_W-1:0] order [NUM_TIMERS];
        logic [ID_W-1:0] swap;
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            // a few arms (and the odd delete), then ticks to let them expire
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 4) == 0)
                    send_req(ACT_DEL, ID_W'($urandom), DELAY_W'($urandom));
                else
                    send_req(ACT_ADD, ID_W'($urandom), DELAY_W'($urandom_range(0, 8)));
            end
            repeat ($urandom_range(1, 10))
                send_req(ACT_TICK, ID_W'($urandom), DELAY_W'($urandom));
        end else if (kind < 58) begin
            // arm every timer close together so one tick can fire many
            for (int i = 0; i < NUM_TIMERS; i++)
                order[i] = ID_W'(i);
            for (int i = NUM_TIMERS - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                swap = order[i];
                order[i] = order[j];
                order[j] = swap;
            end
            for (int i = 0; i < NUM_TIMERS; i++)
                send_req(ACT_ADD, order[i], DELAY_W'($urandom_range(0, 3)));
            repeat (5)
                send_req(ACT_TICK, ID_W'($urandom), DELAY_W'($urandom));
        end else if (kind < 85) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_req(ACT_TICK, ID_W'($urandom), DELAY_W'($urandom));
            else if (pick < 60)
                send_req(ACT_ADD, ID_W'($urandom), DELAY_W'($urandom_range(0, 20)));
            else if (pick < 75)
                send_req(ACT_ADD, ID_W'($urandom), DELAY_W'($urandom));
            else if (pick < 95)
                send_req(ACT_DEL, ID_W'($urandom), DELAY_W'($urandom));
            else
                send_req(ACT_NONE, ID_W'($urandom), DELAY_W'($urandom));
        end else begin
            // noise: unused kind, far-off deadlines, blind deletes
            repeat ($urandom_range(1, 3)) begin
                send_req(ACT_W'($urandom_range(0, 3)), ID_W'($urandom),
                         DELAY_W'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty tick, blind delete, unused kind, farthest deadline,
        // zero delay, ties, re-arm, delete of an armed timer
        send_req(ACT_TICK, 4'hf, '1);
        send_req(ACT_DEL, 4'd5, '0);
        send_req(ACT_NONE, 4'hf, '1);
        send_req(ACT_ADD, 4'hf, '1);
        send_req(ACT_ADD, 4'd0, '0);
        send_req(ACT_ADD, 4'd3, 31'd2);
        send_req(ACT_ADD, 4'd9, 31'd1);
        send_req(ACT_ADD, 4'd4, 31'd1);
        send_req(ACT_ADD, 4'd10, 31'd5);
        send_req(ACT_ADD, 4'd10, 31'd1);
        send_req(ACT_ADD, 4'd7, 31'd3);
        send_req(ACT_DEL, 4'd7, '0);
        send_req(ACT_TICK, 4'd0, '0);
        send_req(ACT_TICK, 4'd0, '0);
        send_req(ACT_TICK, 4'd0, '0);
        send_req(ACT_DEL, 4'hf, '1);
        drain_results();

        while (item_count < 170)
            random_sequence();
        drain_results();
        quiet = 1'b1;
        while (item_count < 300)
            random_sequence();
        drain_results();
        quiet = 1'b0;
        while (item_count < 520)
            random_sequence();

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (2 * (NUM_TIMERS + 3)) @(posedge aclk);

        $display("requests: %0d ticks, %0d adds, %0d deletes, %0d unused kinds",
                 n_tick, n_add, n_del, n_none);
        $display("results checked: %0d, timer expiries: %0d, most on one tick: %0d",
                 sb.checked, sb.expiries, sb.widest_volley);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
